// ===== design/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// shared types and codes for the ordered list engine
// ----------------------------------------------------------------------------
package ole_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic capture;  // latch compare result against incoming value
    logic shift;    // close the gap: take the right neighbour's value if at or after hit
    logic write;    // append: this cell is the tail slot
  } cell_ctrl_t;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

endpackage

// ===== design/ole_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_in_if
// operation channel: valid/ready with op code and value
// ----------------------------------------------------------------------------
interface ole_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== design/ole_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_out_if
// result channel: valid/ready with position, status and count
// ----------------------------------------------------------------------------
interface ole_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] position;
  logic [1:0] status;
  logic [4:0] count;

  modport source (output valid, output position, output status, output count, input ready);
  modport sink   (input valid, input position, input status, input count, output ready);
endinterface

// ===== design/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded list of signed 32-bit values in insertion order: append, search,
// delete first match, built as a row of compare/shift cells
// ----------------------------------------------------------------------------
//  channel | dir | fields                     | transfer when
//  in_i    | in  | op, value                  | valid && ready
//  out_o   | out | position, status, count    | valid && ready
//
//  each item is first compared against every cell as it is taken, then the
//  first-hit chain runs along the row and the item commits (shift or append)
//  a result sits in the output register; a new item is taken while it waits,
//  but its commit holds until the output register is free
//  reset clears the entry count and the control; cell contents need none
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ole_in_if.sink    in_i,
  ole_out_if.source out_o
);
  import ole_pkg::*;

  // count runs 0..DEPTH, position 0..DEPTH
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fsm_e                state_q, state_d;
  logic [1:0]          op_q;
  logic signed [31:0]  value_q;
  logic [CW-1:0]       count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic [PosW-1:0]     out_pos_q, out_pos_d;
  status_e             out_status_q, out_status_d;
  logic [CountW-1:0]   out_count_q, out_count_d;

  logic                accept;
  logic                commit;
  logic                found;
  logic                do_shift;
  logic                do_write;
  logic [CW-1:0]       hit_pos;

  // neighbour chains along the row
  logic                seen  [DEPTH+1];
  logic [CW-1:0]       pos   [DEPTH+1];
  logic signed [31:0]  cval  [DEPTH+1];
  cell_ctrl_t          ctrl  [DEPTH];

  assign in_i.ready = (state_q == FSM_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  // commit once the output register is empty or being drained
  assign commit     = (state_q == FSM_EXEC) && (!out_valid_q || out_o.ready);

  assign seen[0]     = 1'b0;
  assign pos[0]      = '0;
  assign cval[DEPTH] = '0;
  assign found       = seen[DEPTH];
  assign hit_pos     = pos[DEPTH];

  // shift on a found delete, append on an insert with room
  assign do_shift = commit && (op_q == OP_DELETE) && found;
  assign do_write = commit && (op_q == OP_INSERT) && (count_q != CW'(DEPTH));

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign ctrl[g].capture = accept;
    assign ctrl[g].shift   = do_shift;
    assign ctrl[g].write   = do_write && (count_q == CW'(g));

    ole_cell #(
      .Idx  (g),
      .PosW (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .valid_i      (CW'(g) < count_q),
      .cmp_value_i  (in_i.value),
      .wr_value_i   (value_q),
      .next_value_i (cval[g+1]),
      .seen_i       (seen[g]),
      .pos_i        (pos[g]),
      .seen_o       (seen[g+1]),
      .pos_o        (pos[g+1]),
      .value_o      (cval[g])
    );
  end

  // sequencer and result formation
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_pos_d    = out_pos_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (commit) begin
          state_d      = FSM_IDLE;
          out_valid_d  = 1'b1;
          out_pos_d    = '0;
          out_status_d = ST_OK;
          case (op_q)
            OP_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else if (!found) begin
                out_status_d = ST_NOT_FOUND;
              end else begin
                out_pos_d = PosW'(hit_pos);
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else if (!found) begin
                out_status_d = ST_NOT_FOUND;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            default: begin
              // unused code: list untouched, plain ok
            end
          endcase
          out_count_d = CountW'(count_d);
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.op;
      value_q <= in_i.value;
    end
    out_pos_q    <= out_pos_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.position = out_pos_q;
  assign out_o.status   = out_status_q;
  assign out_o.count    = out_count_q;

endmodule

// ===== design/ole_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_cell
// one list slot: holds a value, compares, passes first-hit chain to the right
// ----------------------------------------------------------------------------
module ole_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned PosW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ole_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic signed [31:0]  cmp_value_i,
  input  logic signed [31:0]  wr_value_i,
  input  logic signed [31:0]  next_value_i,
  input  logic                seen_i,
  input  logic [PosW-1:0]     pos_i,
  output logic                seen_o,
  output logic [PosW-1:0]     pos_o,
  output logic signed [31:0]  value_o
);
  import ole_pkg::*;

  logic               match_q;
  logic signed [31:0] value_q, value_d;
  logic               first_hit;

  assign first_hit = match_q & ~seen_i;
  assign seen_o    = seen_i | match_q;
  assign pos_o     = first_hit ? PosW'(Idx + 1) : pos_i;
  assign value_o   = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= valid_i && (value_q == cmp_value_i);
    end
  end

  always_comb begin
    value_d = value_q;
    if (ctrl_i.write) begin
      value_d = wr_value_i;
    end else if (ctrl_i.shift && seen_o) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// sends insert, search, delete and unused-code transfers into the ordered list engine under
// random idling on both channels, keeps a shadow copy of the list to predict
// position, status and count for every accepted operation, and compares them
// ----------------------------------------------------------------------------
module testbench;
  import ole_pkg::*;

  localparam int unsigned ListDepth   = 16;
  localparam int unsigned ItemTarget  = 1550;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned LongHold    = 90;
  // op code with no operation behind it
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct {
    logic [PosW-1:0]   position;
    status_e           status;
    logic [CountW-1:0] count;
  } list_result_t;

  // shadow list plus the results still owed by the block
  class list_ledger;
    logic [ValueW-1:0] slots [ListDepth];
    int unsigned       held = 0;
    list_result_t      owed [$];
    int unsigned       errors = 0;
    int unsigned       checked = 0;
    int unsigned       n_insert = 0, n_search = 0, n_delete = 0, n_unused = 0;
    int unsigned       n_full = 0, n_empty = 0, n_miss = 0, n_hit = 0;
    int unsigned       peak = 0;

    function int unsigned pending();
      return owed.size();
    endfunction

    // work out the result of an accepted operation and update the list
    function void note_op(logic [OpW-1:0] op, logic [ValueW-1:0] value);
      list_result_t r;
      int           hit;
      int           i;
      r.position = '0;
      r.status   = ST_OK;
      hit        = -1;
      for (i = 0; i < int'(held); i++) begin
        if (hit < 0 && slots[i] == value) hit = i;
      end
      case (op)
        OP_INSERT: begin
          n_insert++;
          if (held == ListDepth) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            slots[held] = value;
            held++;
          end
        end
        OP_SEARCH, OP_DELETE: begin
          if (op == OP_SEARCH) n_search++;
          else n_delete++;
          if (held == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else if (hit < 0) begin
            r.status = ST_NOT_FOUND;
            n_miss++;
          end else begin
            n_hit++;
            if (op == OP_SEARCH) begin
              r.position = PosW'(hit + 1);
            end else begin
              // close the gap, keeping the order
              for (i = hit; i + 1 < int'(held); i++) slots[i] = slots[i + 1];
              held--;
            end
          end
        end
        default: n_unused++;
      endcase
      if (held > peak) peak = held;
      r.count = CountW'(held);
      owed.push_back(r);
    endfunction

    function void check_result(logic [PosW-1:0] position, logic [StatusW-1:0] status,
                               logic [CountW-1:0] count);
      list_result_t e;
      if (owed.size() == 0) begin
        $error("result with nothing owed: position %0d status %0d count %0d",
               position, status, count);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (position !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, position);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned offered = 0;   // transfers on the input, unused codes included
  int unsigned counted = 0;   // transfers that carry a real operation
  int unsigned received = 0;  // transfers on the output
  list_ledger  ledger = new();

  ole_in_if  in_ch ();
  ole_out_if out_ch ();

  ordered_list_engine #(
    .DEPTH (ListDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // one operation: optional idle gap, then hold valid until the transfer;
  // valid is only lowered when a gap follows, never within the accepting step
  task automatic send_op(input logic [OpW-1:0] op, input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = ((offered % 256) < 40) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    ledger.note_op(op, value);
    offered++;
    if (op != OpUnused) counted++;
  endtask

  // value mix: entries already held (hits, duplicates), a small pool that
  // collides often, the extremes, and full-width noise
  function automatic logic [ValueW-1:0] pick_value(int unsigned hit_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < hit_pct && ledger.held != 0)
      return ledger.slots[$urandom_range(0, ledger.held - 1)];
    if (r < hit_pct + 25) return ValueW'($urandom_range(0, 7)) - ValueW'(4);
    if (r < hit_pct + 35) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // result side: random readiness, calm stretches, and two long hold-offs so
  // that the block fills and stalls its input
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = ((received % 200) < 40) ? 0 : $urandom_range(0, 6);
      if (received == 300 || received == 1100) gap = LongHold;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      ledger.check_result(out_ch.position, out_ch.status, out_ch.count);
      received++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("timeout after %0d cycles, %0d results still owed", cycles, ledger.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned      i;
    int unsigned      r;
    int unsigned      ins_pct;
    int unsigned      del_pct;
    bit               paused;
    logic [OpW-1:0]   op;
    logic [ValueW-1:0] value;

    paused = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_INSERT;
    in_ch.value <= '0;
    rst_ni      <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: search and delete report empty, the unused code is ignored
    send_op(OP_SEARCH, 32'h0000_0000);
    send_op(OP_DELETE, 32'h7fff_ffff);
    send_op(OpUnused, 32'hffff_ffff);
    // extremes and a duplicate pair
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h7fff_ffff);
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'hffff_ffff);
    send_op(OP_INSERT, 32'h0000_0007);
    send_op(OP_INSERT, 32'h0000_0007);
    send_op(OP_SEARCH, 32'h0000_0007);
    send_op(OP_SEARCH, 32'h0000_0100);
    // only the duplicate nearest the head goes
    send_op(OP_DELETE, 32'h0000_0007);
    send_op(OP_SEARCH, 32'h0000_0007);
    send_op(OP_DELETE, 32'h1234_5678);
    // fill up, then one insert too many, then a hit in the last slot
    for (i = 0; i < 11; i++) send_op(OP_INSERT, 32'd100 + i);
    send_op(OP_INSERT, 32'h5a5a_a5a5);
    send_op(OP_SEARCH, 32'd110);

    // random part in phases that fill, drain and mix the list
    while (counted < ItemTarget) begin
      case ((counted / 150) % 3)
        0: begin
          ins_pct = 65;
          del_pct = 40;
        end
        1: begin
          ins_pct = 20;
          del_pct = 70;
        end
        default: begin
          ins_pct = 45;
          del_pct = 50;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op    = OpUnused;
        value = $urandom();
      end else if (r < 3 + ins_pct) begin
        op    = OP_INSERT;
        value = pick_value(10);
      end else if ($urandom_range(0, 99) < del_pct) begin
        op    = OP_DELETE;
        value = pick_value(ins_pct < 30 ? 75 : 45);
      end else begin
        op    = OP_SEARCH;
        value = pick_value(45);
      end
      send_op(op, value);

      // one pause with the input idle until every result has come back
      if (!paused && counted >= 700) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk_i); while (ledger.pending() != 0);
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
    // a little longer so a stray extra result would still be caught
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d inserts (%0d refused on a full list), %0d searches, %0d deletes,",
             ledger.n_insert, ledger.n_full, ledger.n_search, ledger.n_delete);
    $display("%0d unused codes, %0d hits, %0d misses, %0d on an empty list,",
             ledger.n_unused, ledger.n_hit, ledger.n_miss, ledger.n_empty);
    $display("fill peaked at %0d of %0d, %0d results compared",
             ledger.peak, ListDepth, ledger.checked);
    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
